>>> hdl/zsn_pkg.sv
// zsn_pkg: shared sizes and status codes of the z-score normalizer
// no dependencies; used by z_score_normalizer, its checker and the bench
package zsn_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = 32 + ADDR_W;
    localparam int SQR_W    = 48 + ADDR_W;
    localparam int DIV_W    = SQR_W;
    localparam int DCNT_W   = $clog2(DIV_W + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FLAT = 2'd2;
    localparam logic [1:0] ST_DROP = 2'd3;

endpackage

>>> hdl/z_score_normalizer.sv
// z_score_normalizer: z-score standardization of a population of Q16.16 scores
// depends on zsn_pkg
//
// Usage: drive i_evaluation / i_last with start high; a sample transfers at the
// edge where start is high and busy is low. Samples load one per cycle into a
// 64-entry sample memory, and the one with i_last high closes the population.
// Samples beyond the capacity are dropped (status 3 unless a zero spread gives status 2).
// After the closing transfer busy stays high while a small sequencer drives a
// shared restoring divider (one quotient bit per cycle) and a shared squaring
// multiplier:
//   mean divide        sum magnitude by the sample count
//   deviation pass     per sample: memory read, difference, square, add
//   variance divide    squared-deviation sum by the sample count minus one
//   square root        two steps per result bit (square, compare)
//   each result        memory read, difference, 48-step divide (none for status 1 or 2)
// Each z-score is shown for one cycle with o_strobe high, in load order, with
// o_final_res on the last; the receiver cannot stall, so the block never waits.
// busy falls in the cycle that shows the last result. Reset (synchronous, active
// low) returns to idle with an empty population; the memory is not cleared.
module z_score_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_evaluation,
    input  logic               i_last,
    output logic               o_strobe,
    output logic signed [31:0] o_z_score,
    output logic [1:0]         o_status,
    output logic               o_final_res
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_MEAN_LD  = 14'b00000000000010,
        S_MEAN     = 14'b00000000000100,
        S_SQ_RD    = 14'b00000000001000,
        S_SQ_D     = 14'b00000000010000,
        S_SQ_MUL   = 14'b00000000100000,
        S_SQ_ACC   = 14'b00000001000000,
        S_VAR      = 14'b00000010000000,
        S_ROOT_MUL = 14'b00000100000000,
        S_ROOT_CMP = 14'b00001000000000,
        S_OUT_RD   = 14'b00010000000000,
        S_OUT_D    = 14'b00100000000000,
        S_OUT_DIV  = 14'b01000000000000,
        S_OUT_EMIT = 14'b10000000000000
    } t_state;

    logic signed [31:0] r_mem [zsn_pkg::CAPACITY];
    logic signed [31:0] r_rd_data;

    t_state                          r_state, n_state;
    logic [zsn_pkg::CNT_W-1:0]       r_count, n_count;
    logic signed [zsn_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [zsn_pkg::SQR_W-1:0]       r_sq, n_sq;
    logic signed [31:0]              r_mean, n_mean;
    logic [31:0]                     r_spread, n_spread;
    logic                            r_dropped, n_dropped;
    logic [zsn_pkg::SQR_W-1:0]       r_var, n_var;
    logic [31:0]                     r_root, n_root;
    logic [4:0]                      r_bit, n_bit;
    logic [zsn_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic [31:0]                     r_dm, n_dm;
    logic [63:0]                     r_prod, n_prod;
    logic                            r_neg, n_neg;
    logic [zsn_pkg::DIV_W-1:0]       r_dq, n_dq;
    logic [31:0]                     r_rem, n_rem;
    logic [31:0]                     r_div, n_div;
    logic [zsn_pkg::DCNT_W-1:0]      r_dcnt, n_dcnt;
    logic [1:0]                      r_status, n_status;
    logic                            r_strobe, n_strobe;
    logic signed [31:0]              r_z, n_z;
    logic                            r_final, n_final;

    logic                            accept;
    logic                            room;
    logic signed [32:0]              diff;
    logic [32:0]                     neg_diff;
    logic [31:0]                     mag;
    logic [zsn_pkg::SUM_W-1:0]       sum_mag;
    logic [32:0]                     rem_sh;
    logic [32:0]                     rem_sub;
    logic                            rem_ge;
    logic [31:0]                     cand;
    logic [31:0]                     mul_a;
    logic [zsn_pkg::SQR_W+15:0]      var_scaled;
    logic [zsn_pkg::SQR_W+15:0]      prod_ext;
    logic                            last_idx;
    logic [47:0]                     quo;
    logic [31:0]                     z_val;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign room        = (r_count < zsn_pkg::CNT_W'(zsn_pkg::CAPACITY));
    assign o_strobe    = r_strobe;
    assign o_z_score   = r_z;
    assign o_status    = r_status;
    assign o_final_res = r_final;

    // sample memory: one write port for loading, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_mem[r_count[zsn_pkg::ADDR_W-1:0]] <= i_evaluation;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_comb begin
        diff     = {r_rd_data[31], r_rd_data} - {r_mean[31], r_mean};
        neg_diff = -diff;
        mag      = diff[32] ? neg_diff[31:0] : diff[31:0];
        sum_mag  = r_sum[zsn_pkg::SUM_W-1] ? zsn_pkg::SUM_W'(-r_sum) : zsn_pkg::SUM_W'(r_sum);
        // restoring divider step
        rem_sh   = {r_rem, r_dq[zsn_pkg::DIV_W-1]};
        rem_ge   = (rem_sh >= {1'b0, r_div});
        rem_sub  = rem_sh - {1'b0, r_div};
        // root trial bit and shared squaring multiplier operand
        cand     = r_root | (32'd1 << r_bit);
        mul_a    = (r_state == S_SQ_MUL) ? r_dm : cand;
        var_scaled = {r_var, 16'd0};
        prod_ext   = (zsn_pkg::SQR_W + 16)'(r_prod);
        last_idx   = ({1'b0, r_idx} == zsn_pkg::CNT_W'(r_count - 1'b1));
        quo        = r_dq[47:0];
        if (r_neg) begin
            z_val = (quo > 48'h0000_8000_0000) ? 32'h8000_0000 : quo[31:0];
            z_val = -z_val;
        end else begin
            z_val = (quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sum     = r_sum;
        n_sq      = r_sq;
        n_mean    = r_mean;
        n_spread  = r_spread;
        n_dropped = r_dropped;
        n_var     = r_var;
        n_root    = r_root;
        n_bit     = r_bit;
        n_idx     = r_idx;
        n_dm      = r_dm;
        n_prod    = r_prod;
        n_neg     = r_neg;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_div     = r_div;
        n_dcnt    = r_dcnt;
        n_status  = r_status;
        n_strobe  = 1'b0;
        n_z       = r_z;
        n_final   = r_final;

        if (r_state == S_MEAN || r_state == S_VAR || r_state == S_OUT_DIV) begin
            if (r_dcnt != '0) begin
                n_rem  = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                n_dq   = {r_dq[zsn_pkg::DIV_W-2:0], rem_ge};
                n_dcnt = r_dcnt - 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (room) begin
                        n_count = r_count + 1'b1;
                        n_sum   = r_sum + zsn_pkg::SUM_W'(i_evaluation);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_state = S_MEAN_LD;
                    end
                end
            end
            S_MEAN_LD: begin
                n_dq    = {sum_mag, {(zsn_pkg::DIV_W - zsn_pkg::SUM_W){1'b0}}};
                n_rem   = '0;
                n_div   = 32'(r_count);
                n_dcnt  = zsn_pkg::DCNT_W'(zsn_pkg::SUM_W);
                n_sq    = '0;
                n_idx   = '0;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (r_dcnt == '0) begin
                    n_mean = r_sum[zsn_pkg::SUM_W-1] ? -$signed(r_dq[31:0]) : $signed(r_dq[31:0]);
                    if (r_count < zsn_pkg::CNT_W'(2)) begin
                        n_spread = '0;
                        n_status = zsn_pkg::ST_FEW;
                        n_state  = S_OUT_RD;
                    end else begin
                        n_state = S_SQ_RD;
                    end
                end
            end
            S_SQ_RD: begin
                n_state = S_SQ_D;
            end
            S_SQ_D: begin
                n_dm    = mag;
                n_state = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                n_prod  = mul_a * mul_a;
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                n_sq = r_sq + zsn_pkg::SQR_W'(r_prod[63:16]);
                if (last_idx) begin
                    n_dq    = r_sq + zsn_pkg::SQR_W'(r_prod[63:16]);
                    n_rem   = '0;
                    n_div   = 32'(r_count) - 32'd1;
                    n_dcnt  = zsn_pkg::DCNT_W'(zsn_pkg::DIV_W);
                    n_idx   = '0;
                    n_state = S_VAR;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SQ_RD;
                end
            end
            S_VAR: begin
                if (r_dcnt == '0) begin
                    n_var   = r_dq;
                    n_root  = '0;
                    n_bit   = 5'd31;
                    n_state = S_ROOT_MUL;
                end
            end
            S_ROOT_MUL: begin
                n_prod  = mul_a * mul_a;
                n_state = S_ROOT_CMP;
            end
            S_ROOT_CMP: begin
                if (prod_ext <= var_scaled) begin
                    n_root = cand;
                end
                if (r_bit == 5'd0) begin
                    n_spread = (prod_ext <= var_scaled) ? cand : r_root;
                    if ((prod_ext <= var_scaled ? cand : r_root) == 32'd0) begin
                        n_status = zsn_pkg::ST_FLAT;
                    end else if (r_dropped) begin
                        n_status = zsn_pkg::ST_DROP;
                    end else begin
                        n_status = zsn_pkg::ST_OK;
                    end
                    n_state = S_OUT_RD;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_ROOT_MUL;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_D;
            end
            S_OUT_D: begin
                n_neg = diff[32];
                if (r_status == zsn_pkg::ST_OK || r_status == zsn_pkg::ST_DROP) begin
                    n_dq    = {mag, {(zsn_pkg::DIV_W - 32){1'b0}}};
                    n_rem   = '0;
                    n_div   = r_spread;
                    n_dcnt  = zsn_pkg::DCNT_W'(48);
                    n_state = S_OUT_DIV;
                end else begin
                    n_dq    = '0;
                    n_state = S_OUT_EMIT;
                end
            end
            S_OUT_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = S_OUT_EMIT;
                end
            end
            S_OUT_EMIT: begin
                n_strobe = 1'b1;
                n_z      = z_val;
                n_final  = last_idx;
                if (last_idx) begin
                    n_count   = '0;
                    n_sum     = '0;
                    n_sq      = '0;
                    n_dropped = 1'b0;
                    n_idx     = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_mean    <= '0;
            r_spread  <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_strobe  <= 1'b0;
            r_final   <= 1'b0;
            r_status  <= zsn_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_sq      <= n_sq;
            r_mean    <= n_mean;
            r_spread  <= n_spread;
            r_dropped <= n_dropped;
            r_idx     <= n_idx;
            r_strobe  <= n_strobe;
            r_final   <= n_final;
            r_status  <= n_status;
        end
        r_var  <= n_var;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_dm   <= n_dm;
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_dcnt <= n_dcnt;
        r_z    <= n_z;
    end

endmodule

>>> hdl/zsn_checker.sv
// zsn_checker: port-level checks of the z-score normalizer over time
// depends on zsn_pkg; bound to z_score_normalizer at the end of this file
module zsn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic        o_final_res
);

    // a non-closing transfer keeps the block loading
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_last |=> !busy)
        else $error("busy after a non-closing transfer");

    // the closing transfer starts the computation
    a_close_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last |=> busy)
        else $error("not busy after the closing transfer");

    // results other than the final one are shown while still busy
    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_final_res |-> busy)
        else $error("intermediate result while idle");

    // the final result frees the block
    a_final_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_final_res |-> !busy)
        else $error("still busy at the final result");

    // status code is the same across one run's results
    a_status_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_final_res |=> $stable(o_status) ||
            o_status == zsn_pkg::ST_OK && $past(o_status) == zsn_pkg::ST_OK)
        else $error("status changed within a run");

endmodule

bind z_score_normalizer zsn_checker u_zsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_last      (i_last),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_final_res (o_final_res)
);

>>> tb/sv/tb_z_score_normalizer.sv
// tb_z_score_normalizer: self-checking bench for the z-score normalizer
// depends on zsn_pkg and z_score_normalizer; directed table, an overfull store, then random populations
`timescale 1ns / 100ps

module tb_z_score_normalizer;

    typedef struct {
        logic signed [31:0] z;
        logic [1:0]         status;
        logic               final_res;
    } t_zres;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               typed;  // expected result typed in below
        logic signed [31:0] z;
        logic [1:0]         status;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [31:0] i_evaluation = '0;
    logic               i_last = 1'b0;
    wire                busy;
    wire                o_strobe;
    wire signed [31:0]  o_z_score;
    wire [1:0]          o_status;
    wire                o_final_res;

    z_score_normalizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_evaluation(i_evaluation), .i_last(i_last), .o_strobe(o_strobe),
        .o_z_score(o_z_score), .o_status(o_status), .o_final_res(o_final_res)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] pop_store [zsn_pkg::CAPACITY];
    int                 pop_count = 0;
    logic signed [63:0] pop_sum = '0;
    logic               pop_dropped = 1'b0;
    t_zres              z_expected [$];
    int                 errors = 0;
    int                 samples_sent = 0;
    int                 results_seen = 0;
    int                 idle_cycles = 0;
    int                 populations = 0;

    function automatic logic [31:0] isqrt_q16(logic [63:0] var_q);
        logic [63:0] r, c, t, up;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            t = c * c;
            up = (t >> 16) + ((t[15:0] != 0) ? 64'd1 : 64'd0);
            if (up <= var_q) r = c;
        end
        return r[31:0];
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    task automatic predict_sample(logic signed [31:0] x, logic is_last);
        int n;
        logic signed [63:0] d;
        logic signed [31:0] mean;
        logic [63:0] q, sq, dm;
        logic [31:0] spread;
        logic [1:0] st;
        t_zres r;
        if (pop_count < zsn_pkg::CAPACITY) begin
            pop_store[pop_count] = x;
            pop_count++;
            pop_sum += x;
        end else begin
            pop_dropped = 1'b1;
        end
        if (!is_last) return;
        n = pop_count;
        populations++;
        q = mag64(pop_sum) / n;
        mean = (pop_sum < 0) ? -$signed(q[31:0]) : q[31:0];
        sq = 0;
        spread = 0;
        if (n >= 2) begin
            for (int i = 0; i < n; i++) begin
                dm = mag64(64'(pop_store[i]) - 64'(mean));
                sq += (dm * dm) >> 16;
            end
            spread = isqrt_q16(sq / (n - 1));
        end
        if (n < 2) st = zsn_pkg::ST_FEW;
        else if (spread == 0) st = zsn_pkg::ST_FLAT;
        else if (pop_dropped) st = zsn_pkg::ST_DROP;
        else st = zsn_pkg::ST_OK;
        for (int i = 0; i < n; i++) begin
            r.z = 0;
            if (st == zsn_pkg::ST_OK || st == zsn_pkg::ST_DROP) begin
                d = 64'(pop_store[i]) - 64'(mean);
                q = (mag64(d) << 16) / spread;
                if (d < 0) begin
                    if (q > 64'h8000_0000) q = 64'h8000_0000;
                    r.z = -$signed(q[31:0]);
                end else begin
                    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                    r.z = q[31:0];
                end
            end
            r.status = st;
            r.final_res = (i + 1 == n);
            z_expected.push_back(r);
        end
        pop_count = 0;
        pop_sum = 0;
        pop_dropped = 1'b0;
    endtask

    // result checker, sampled at every edge where o_strobe is high
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (z_expected.size() == 0) begin
                $display("%0t: unexpected result z=%h status=%0d", $time, o_z_score, o_status);
                errors++;
            end else begin
                t_zres e;
                e = z_expected.pop_front();
                if (e.z !== o_z_score || e.status !== o_status ||
                    e.final_res !== o_final_res) begin
                    $display("%0t: mismatch expected z=%h st=%0d fin=%0b actual z=%h st=%0d fin=%0b",
                             $time, e.z, e.status, e.final_res,
                             o_z_score, o_status, o_final_res);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("z_score_normalizer test failed");
            $finish;
        end
    end

    task automatic send_sample(logic signed [31:0] x, logic is_last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_evaluation <= x;
        i_last <= is_last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_sample(x, is_last);
        samples_sent++;
    endtask

    t_row dir_rows [$];

    function automatic t_row mk(logic signed [31:0] v, logic l, logic t = 0,
                                logic signed [31:0] z = 0,
                                logic [1:0] s = zsn_pkg::ST_OK);
        t_row r;
        r.value = v; r.last = l; r.typed = t; r.z = z; r.status = s;
        return r;
    endfunction

    initial begin
        int n, kind;
        logic signed [31:0] base;
        // single sample: status few, zero z
        dir_rows.push_back(mk(32'sh7FFF_FFFF, 1'b1, 1'b1, 0, zsn_pkg::ST_FEW));
        dir_rows.push_back(mk(32'sh8000_0000, 1'b1, 1'b1, 0, zsn_pkg::ST_FEW));
        // equal samples: zero spread
        dir_rows.push_back(mk(32'sh0001_0000, 1'b0));
        dir_rows.push_back(mk(32'sh0001_0000, 1'b1, 1'b1, 0, zsn_pkg::ST_FLAT));
        // extremes together
        dir_rows.push_back(mk(32'sh7FFF_FFFF, 1'b0));
        dir_rows.push_back(mk(32'sh8000_0000, 1'b1));
        dir_rows.push_back(mk(32'sh8000_0000, 1'b0));
        dir_rows.push_back(mk(32'sh8000_0000, 1'b0));
        dir_rows.push_back(mk(32'sh7FFF_FFFF, 1'b1));
        // tiny differences: spread rounds to zero (flat), then a wide mixed population
        dir_rows.push_back(mk(32'sd0, 1'b0));
        dir_rows.push_back(mk(32'sd1, 1'b0));
        dir_rows.push_back(mk(32'sd0, 1'b1));
        dir_rows.push_back(mk(-32'sd3, 1'b0));
        dir_rows.push_back(mk(32'sd5, 1'b0));
        dir_rows.push_back(mk(32'sh5555_5555, 1'b0));
        dir_rows.push_back(mk(-32'sh2AAA_AAAA, 1'b1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_sample(dir_rows[k].value, dir_rows[k].last);
            if (dir_rows[k].typed) begin
                foreach (z_expected[j])
                    if (z_expected[j].z !== dir_rows[k].z ||
                        z_expected[j].status !== dir_rows[k].status) begin
                        $display("%0t: predictor expected z=%h st=%0d got z=%h st=%0d",
                                 $time, dir_rows[k].z, dir_rows[k].status,
                                 z_expected[j].z, z_expected[j].status);
                        errors++;
                    end
            end
        end
        // overfull store: capacity plus three dropped
        for (int i = 0; i < zsn_pkg::CAPACITY + 3; i++)
            send_sample($urandom, i == zsn_pkg::CAPACITY + 2);

        while (samples_sent < 470) begin
            kind = $urandom_range(0, 9);
            n = (kind == 0) ? $urandom_range(zsn_pkg::CAPACITY - 2, zsn_pkg::CAPACITY + 4)
                            : $urandom_range(1, 8);
            base = $urandom;
            for (int i = 0; i < n; i++) begin
                case (kind)
                    1: send_sample(base, i == n - 1);                       // flat
                    2: send_sample(base + $signed($urandom_range(0, 3)), i == n - 1);
                    3, 4: send_sample($urandom, i == n - 1);                // full range
                    default: send_sample((base >>> $urandom_range(4, 16))
                                         + $signed($urandom_range(0, 32'h000F_FFFF)),
                                         i == n - 1);
                endcase
            end
        end
        start <= 1'b0;

        while (z_expected.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d samples in %0d populations, %0d z-scores checked",
                 samples_sent, populations, results_seen);
        if (errors == 0) begin
            $display("z_score_normalizer test passed");
        end else begin
            $display("z_score_normalizer test failed");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/zsn_pkg.sv
hdl/z_score_normalizer.sv
hdl/zsn_checker.sv
tb/sv/tb_z_score_normalizer.sv
